// ===== rtl/pfcs_pkg.sv =====
// Shared types, command constants and helpers for the flash command sequencer.
// No dependencies; every other file in rtl/ but pfcs_checker refers to this package by scoped names.
package pfcs_pkg;

   // Bus address port width and the number of address bits the flash really decodes.
   localparam int ADDR_W    = 17;
   localparam int ADDR_BITS = 17;
   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

   localparam int WAIT_W  = 18;
   localparam int STEP_W  = 3;
   localparam int CSR_IDX_W = 2;

   // Command queue between front and back.
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);

   // Request modes.
   localparam logic [2:0] MODE_ID      = 3'd0;
   localparam logic [2:0] MODE_ERASE   = 3'd1;
   localparam logic [2:0] MODE_PROG    = 3'd2;
   localparam logic [2:0] MODE_PAIR    = 3'd3;
   localparam logic [2:0] MODE_READ    = 3'd4;
   localparam logic [2:0] MODE_CAPTURE = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // Wait selectors.
   localparam logic [1:0] WAIT_NONE  = 2'd0;
   localparam logic [1:0] WAIT_ID    = 2'd1;
   localparam logic [1:0] WAIT_PROG  = 2'd2;
   localparam logic [1:0] WAIT_ERASE = 2'd3;

   // CSR indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_PULSE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ID_SETTLE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROG_SETTLE  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_SETTLE = 2'd3;

   // JEDEC unlock addresses and command bytes.
   localparam logic [ADDR_W-1:0] UNLOCK_A     = 17'h05555;
   localparam logic [ADDR_W-1:0] UNLOCK_B     = 17'h02AAA;
   localparam logic [ADDR_W-1:0] ID_EXIT_ADDR = 17'h01234;
   localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0] CMD_PROGRAM = 8'hA0;
   localparam logic [7:0] CMD_ER_SETUP = 8'h80;
   localparam logic [7:0] CMD_CHIP_ER = 8'h10;
   localparam logic [7:0] CMD_ID_ENTR = 8'h90;
   localparam logic [7:0] CMD_ID_EXIT = 8'hF0;

   localparam int ERASE_US_PER_MS = 1000;

   typedef struct packed {
      logic [7:0] write_pulse_us;
      logic [7:0] id_settle_us;
      logic [7:0] program_settle_us;
      logic [7:0] erase_settle_ms;
   } cfg_type;

   // One classified request waiting for the back end; data bytes already in pin order.
   typedef struct packed {
      logic [2:0]        op;
      logic              chip;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        d0_rev;
      logic [7:0]        d1_rev;
      logic [7:0]        pins_rev;
      logic [STEP_W-1:0] last_step;
   } desc_type;

   function automatic logic [7:0] flip8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) begin
         r[7-i] = v[i];
      end
      return r;
   endfunction

endpackage

// ===== rtl/pfcs_front.sv =====
// Front end: decodes a request beat into a command descriptor.
// Depends on pfcs_pkg. Unused mode codes produce no descriptor.
module pfcs_front (
   input  logic [2:0]                 mode,
   input  logic                       chip_sel,
   input  logic [pfcs_pkg::ADDR_W-1:0] address,
   input  logic [7:0]                 data_first,
   input  logic [7:0]                 data_second,
   input  logic [7:0]                 pin_byte,
   output logic                       desc_valid,
   output pfcs_pkg::desc_type         desc
);

   always_comb begin
      desc_valid     = 1'b1;
      desc.op        = mode;
      desc.chip      = chip_sel;
      desc.addr      = address;
      desc.d0_rev    = pfcs_pkg::flip8(data_first);
      desc.d1_rev    = pfcs_pkg::flip8(data_second);
      desc.pins_rev  = pfcs_pkg::flip8(pin_byte);
      desc.last_step = '0;
      unique case (mode)
         pfcs_pkg::MODE_ID:      desc.last_step = 3'd5;
         pfcs_pkg::MODE_ERASE:   desc.last_step = 3'd5;
         pfcs_pkg::MODE_PROG:    desc.last_step = 3'd3;
         pfcs_pkg::MODE_PAIR:    desc.last_step = 3'd7;
         pfcs_pkg::MODE_READ:    desc.last_step = 3'd0;
         pfcs_pkg::MODE_CAPTURE: desc.last_step = 3'd0;
         default:                desc_valid     = 1'b0;
      endcase
   end

endmodule

// ===== rtl/pfcs_queue.sv =====
// Two-entry descriptor queue between the request decoder and the cycle generator.
// Depends on pfcs_pkg.
module pfcs_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfcs_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output pfcs_pkg::desc_type head
);

   pfcs_pkg::desc_type                  entry_ff [pfcs_pkg::QDEPTH];
   logic [pfcs_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pfcs_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pfcs_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                        do_push, do_pop;

   assign full       = (count_ff == pfcs_pkg::QCNT_W'(pfcs_pkg::QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == pfcs_pkg::QPTR_W'(pfcs_pkg::QDEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == pfcs_pkg::QPTR_W'(pfcs_pkg::QDEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/pfcs_back.sv =====
// Back end: walks the queue head step by step and registers one bus cycle per beat.
// Depends on pfcs_pkg; reads the CSR values live (the user is to change them only while idle; not enforced here).
module pfcs_back (
   input  logic                        clock,
   input  logic                        reset,
   input  pfcs_pkg::cfg_type           cfg,
   input  logic                        head_valid,
   input  pfcs_pkg::desc_type          head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [63:0]                 rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);

   logic [pfcs_pkg::STEP_W-1:0] step_ff, step_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [63:0]                 rsp_data_ff;
   logic [1:0]                  rsp_user_ff;
   logic                        rsp_last_ff;

   logic                        emit;
   logic                        is_last;
   logic [1:0]                  kind;
   logic                        chip;
   logic [pfcs_pkg::ADDR_W-1:0] addr;
   logic [7:0]                  data_rev;
   logic [7:0]                  read_val;
   logic [1:0]                  wait_sel;
   logic [pfcs_pkg::WAIT_W-1:0] wait_us;
   logic [7:0]                  pulse;

   assign emit    = head_valid && (!rsp_valid_ff || rsp_tready);
   assign is_last = (step_ff == head.last_step);
   assign pop     = emit && is_last;

   // Per-step cycle table.
   always_comb begin
      kind     = pfcs_pkg::KIND_WRITE;
      chip     = head.chip;
      addr     = '0;
      data_rev = '0;
      read_val = '0;
      wait_sel = pfcs_pkg::WAIT_NONE;
      unique case (head.op)
         pfcs_pkg::MODE_ID: begin
            case (step_ff)
               3'd0: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK1);
               end
               3'd1: begin
                  addr = pfcs_pkg::UNLOCK_B; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK2);
               end
               3'd2: begin
                  addr     = pfcs_pkg::UNLOCK_A;
                  data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_ID_ENTR);
                  wait_sel = pfcs_pkg::WAIT_ID;
               end
               3'd3: begin
                  kind = pfcs_pkg::KIND_READ; addr = '0;
               end
               3'd4: begin
                  kind = pfcs_pkg::KIND_READ; addr = pfcs_pkg::ADDR_W'(1);
               end
               default: begin
                  addr     = pfcs_pkg::ID_EXIT_ADDR;
                  data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_ID_EXIT);
                  wait_sel = pfcs_pkg::WAIT_ID;
               end
            endcase
         end
         pfcs_pkg::MODE_ERASE: begin
            case (step_ff)
               3'd0, 3'd3: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK1);
               end
               3'd1, 3'd4: begin
                  addr = pfcs_pkg::UNLOCK_B; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK2);
               end
               3'd2: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_ER_SETUP);
               end
               default: begin
                  addr     = pfcs_pkg::UNLOCK_A;
                  data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_CHIP_ER);
                  wait_sel = pfcs_pkg::WAIT_ERASE;
               end
            endcase
         end
         pfcs_pkg::MODE_PROG: begin
            case (step_ff)
               3'd0: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK1);
               end
               3'd1: begin
                  addr = pfcs_pkg::UNLOCK_B; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK2);
               end
               3'd2: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_PROGRAM);
               end
               default: begin
                  addr = head.addr; data_rev = head.d0_rev; wait_sel = pfcs_pkg::WAIT_PROG;
               end
            endcase
         end
         pfcs_pkg::MODE_PAIR: begin
            // chips alternate on every beat: step bit 0 picks the chip
            chip = step_ff[0];
            case (step_ff[2:1])
               2'd0: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK1);
               end
               2'd1: begin
                  addr = pfcs_pkg::UNLOCK_B; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_UNLOCK2);
               end
               2'd2: begin
                  addr = pfcs_pkg::UNLOCK_A; data_rev = pfcs_pkg::flip8(pfcs_pkg::CMD_PROGRAM);
               end
               default: begin
                  addr     = head.addr;
                  data_rev = step_ff[0] ? head.d1_rev : head.d0_rev;
                  wait_sel = step_ff[0] ? pfcs_pkg::WAIT_PROG : pfcs_pkg::WAIT_NONE;
               end
            endcase
         end
         pfcs_pkg::MODE_READ: begin
            kind = pfcs_pkg::KIND_READ;
            addr = head.addr;
         end
         pfcs_pkg::MODE_CAPTURE: begin
            kind     = pfcs_pkg::KIND_DATA;
            read_val = head.pins_rev;
         end
         default: begin
            kind = pfcs_pkg::KIND_WRITE;
         end
      endcase
   end

   always_comb begin
      unique case (wait_sel)
         pfcs_pkg::WAIT_NONE:  wait_us = '0;
         pfcs_pkg::WAIT_ID:    wait_us = pfcs_pkg::WAIT_W'(cfg.id_settle_us);
         pfcs_pkg::WAIT_PROG:  wait_us = pfcs_pkg::WAIT_W'(cfg.program_settle_us);
         pfcs_pkg::WAIT_ERASE: wait_us = pfcs_pkg::WAIT_W'(
            pfcs_pkg::WAIT_W'(cfg.erase_settle_ms) *
            pfcs_pkg::WAIT_W'(pfcs_pkg::ERASE_US_PER_MS));
         default:              wait_us = '0;
      endcase
   end

   assign pulse = (kind == pfcs_pkg::KIND_WRITE) ? cfg.write_pulse_us : 8'd0;

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         step_in      = is_last ? '0 : step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= {4'd0, wait_us, pulse, read_val, data_rev,
                         addr & pfcs_pkg::ADDR_MASK, chip};
         rsp_user_ff <= kind;
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/parallel_flash_command_sequencer.sv =====
// Top level of the flash command sequencer: CSR file, request decoder, queue, cycle generator.
// Depends on pfcs_pkg, pfcs_front, pfcs_queue and pfcs_back.
//
// Each request beat expands into its bus cycles, one result beat per clock while
// rsp_tready is high: id read 6 beats, erase 6, program byte 4, program pair 8, read 1,
// capture 1; mode codes 6 and 7 are taken and dropped. The rate is set by the cycle
// generator, which steps through one queued command at one beat a clock while rsp_tready
// is high and moves to the next command on the clock after the last beat. A two-entry
// command queue sits between the request decoder and the generator, so requests are taken
// while earlier ones are still being played out; with the generator idle, a taken request
// is first written into the queue and its first result beat is then registered at the output.
// CSRs are to be written only while idle.
module parallel_flash_command_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [47:0]                      req_tdata, // chip_sel, address[16:0], data_first,
                                                       // data_second, pin_byte, 6'b0 pad
   input  logic [2:0]                       req_tuser, // mode
   // result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [63:0]                      rsp_tdata, // chip_index, bus_address[16:0],
                                                       // pin_data, read_value, pulse_us,
                                                       // wait_after_us[17:0], 4'b0 pad
   output logic [1:0]                       rsp_tuser, // cycle_kind
   output logic                             rsp_tlast, // last
   // csr write port
   input  logic                             csr_we,
   input  logic [pfcs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [7:0]                       csr_wdata
);

   pfcs_pkg::cfg_type  cfg_ff, cfg_in;
   pfcs_pkg::desc_type front_desc, head;
   logic               front_valid;
   logic               q_full, head_valid, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pfcs_pkg::CSR_WRITE_PULSE:  cfg_in.write_pulse_us    = csr_wdata;
            pfcs_pkg::CSR_ID_SETTLE:    cfg_in.id_settle_us      = csr_wdata;
            pfcs_pkg::CSR_PROG_SETTLE:  cfg_in.program_settle_us = csr_wdata;
            pfcs_pkg::CSR_ERASE_SETTLE: cfg_in.erase_settle_ms   = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.write_pulse_us    <= 8'd20;
         cfg_ff.id_settle_us      <= 8'd20;
         cfg_ff.program_settle_us <= 8'd22;
         cfg_ff.erase_settle_ms   <= 8'd150;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_tready = !q_full;

   pfcs_front u_front (
      .mode        (req_tuser),
      .chip_sel    (req_tdata[0]),
      .address     (req_tdata[17:1]),
      .data_first  (req_tdata[25:18]),
      .data_second (req_tdata[33:26]),
      .pin_byte    (req_tdata[41:34]),
      .desc_valid  (front_valid),
      .desc        (front_desc)
   );

   pfcs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_tvalid && front_valid),
      .push_desc  (front_desc),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   pfcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/pfcs_checker.sv =====
// Port-level checks for the flash command sequencer, bound to the top level.
// Depends on the top level's port list only.
module pfcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_DATA = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // first cycle out of reset only; the very first edge has no reset history yet
   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != KIND_BAD)
      else $error("illegal cycle kind");

   a_data_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |-> rsp_tlast && rsp_tdata[17:1] == 17'd0)
      else $error("captured data beat not a lone final beat");

   a_read_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_READ |-> rsp_tdata[25:18] == 8'd0
         && rsp_tdata[41:34] == 8'd0 && rsp_tdata[59:42] == 18'd0)
      else $error("read cycle carries write data, strobe or wait");

endmodule

bind parallel_flash_command_sequencer pfcs_checker u_pfcs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
